### hw/rtl/utf8_display_label_filter_macros.svh
// Assertion helpers shared by the filter modules.
`ifndef UTF8_DISPLAY_LABEL_FILTER_MACROS_SVH
`define UTF8_DISPLAY_LABEL_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define UDLF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define UDLF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/udlf_pkg.sv
`default_nettype none
package udlf_pkg;

  localparam int QUEUE_DEPTH = 4;

  // Register map
  localparam logic [7:0] CAPACITY_RESET = 8'd32;

  // Character codes
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] LEAD_C3   = 8'hC3;
  localparam logic [7:0] UML_A_UP  = 8'h84;
  localparam logic [7:0] UML_A_LO  = 8'hA4;
  localparam logic [7:0] RING_A_UP = 8'h85;
  localparam logic [7:0] RING_A_LO = 8'hA5;
  localparam logic [7:0] UML_O_UP  = 8'h96;
  localparam logic [7:0] UML_O_LO  = 8'hB6;

  // One byte's worth of results: qn '?' marks, then tn trailing bytes
  typedef struct packed {
    logic [1:0] qn;
    logic [1:0] tn;
    logic [7:0] t0;
    logic [7:0] t1;
    logic       eol;
  } job_t;

  // ASCII folding: upper case, allowed set passes, rest becomes '?'
  function automatic logic [7:0] map_ascii(input logic [7:0] b);
    logic [7:0] up;
    up = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
    if ((up >= 8'h41 && up <= 8'h5A) || (up >= 8'h30 && up <= 8'h39) ||
        up == 8'h20 || up == 8'h2D || up == 8'h2E || up == 8'h5F)
      return up;
    return CH_QMARK;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/udlf_front.sv
`default_nettype none
`include "utf8_display_label_filter_macros.svh"
module udlf_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     in_byte,
  input  wire logic [7:0]     capacity,
  output udlf_pkg::job_t      job,
  output logic                job_valid
);

  logic [7:0] pending_lead, pending_lead_next;
  logic [1:0] pending_needed, pending_needed_next;
  logic [1:0] pending_count, pending_count_next;
  logic [7:0] written_count, written_count_next;
  logic       stopped, stopped_next;

  logic       is_eol, is_cont, lead_c3;
  logic [1:0] lead_need;
  logic [7:0] start_char;
  logic [2:0] cnt_inc;
  logic [1:0] k;
  logic       has_trail;
  logic [1:0] trail_len;
  logic [7:0] trail0, trail1;
  logic [8:0] room, room2;
  logic       stop1, trail_ok;
  logic [1:0] q_emit;
  logic [7:0] umlaut;

  // Classify the incoming byte
  always_comb begin
    is_eol  = (in_byte == udlf_pkg::CH_NUL);
    is_cont = (in_byte[7:6] == 2'b10);
    lead_c3 = (pending_lead == udlf_pkg::LEAD_C3) && (pending_needed == 2'd1);
    if (in_byte >= 8'hC2 && in_byte <= 8'hDF)      lead_need = 2'd1;
    else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) lead_need = 2'd2;
    else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) lead_need = 2'd3;
    else                                           lead_need = 2'd0;
    start_char = in_byte[7] ? udlf_pkg::CH_QMARK : udlf_pkg::map_ascii(in_byte);
    case (in_byte)
      udlf_pkg::UML_A_UP, udlf_pkg::UML_A_LO:   umlaut = udlf_pkg::UML_A_UP;
      udlf_pkg::RING_A_UP, udlf_pkg::RING_A_LO: umlaut = udlf_pkg::RING_A_UP;
      udlf_pkg::UML_O_UP, udlf_pkg::UML_O_LO:   umlaut = udlf_pkg::UML_O_UP;
      default:                                  umlaut = udlf_pkg::CH_NUL;
    endcase
    cnt_inc = {1'b0, pending_count} + 3'd1;
  end

  // Work out the items this byte asks for and the capacity cut
  always_comb begin
    k         = 2'd0;
    has_trail = 1'b0;
    trail_len = 2'd1;
    trail0    = udlf_pkg::CH_QMARK;
    trail1    = udlf_pkg::CH_NUL;

    if (!stopped) begin
      if (is_eol) begin
        if (pending_needed != 2'd0) k = pending_count + 2'd1;
      end else if (pending_needed != 2'd0 && is_cont) begin
        if (cnt_inc >= {1'b0, pending_needed}) begin
          has_trail = 1'b1;
          if (lead_c3 && umlaut != udlf_pkg::CH_NUL) begin
            trail_len = 2'd2;
            trail0    = udlf_pkg::LEAD_C3;
            trail1    = umlaut;
          end
        end
      end else begin
        if (pending_needed != 2'd0) k = pending_count + 2'd1;
        has_trail = (lead_need == 2'd0);
        trail0    = start_char;
      end
    end

    room = ({1'b0, capacity} > {1'b0, written_count}) ?
           ({1'b0, capacity} - {1'b0, written_count} - 9'd1) : 9'd0;
    stop1    = ({7'd0, k} > room);
    q_emit   = stop1 ? room[1:0] : k;
    room2    = room - {7'd0, k};
    trail_ok = has_trail && !stop1 && ({7'd0, trail_len} <= room2);
  end

  // Next state
  always_comb begin
    pending_lead_next   = pending_lead;
    pending_needed_next = pending_needed;
    pending_count_next  = pending_count;
    written_count_next  = written_count + {6'd0, q_emit} + (trail_ok ? {6'd0, trail_len} : 8'd0);
    stopped_next        = stopped | stop1 | (has_trail && !stop1 && !trail_ok);

    if (is_eol) begin
      pending_lead_next   = 8'd0;
      pending_needed_next = 2'd0;
      pending_count_next  = 2'd0;
      written_count_next  = 8'd0;
      stopped_next        = 1'b0;
    end else if (stopped) begin
      pending_lead_next   = 8'd0;
      pending_needed_next = 2'd0;
      pending_count_next  = 2'd0;
    end else if (pending_needed != 2'd0 && is_cont) begin
      if (cnt_inc >= {1'b0, pending_needed}) begin
        pending_lead_next   = 8'd0;
        pending_needed_next = 2'd0;
        pending_count_next  = 2'd0;
      end else begin
        pending_count_next  = cnt_inc[1:0];
      end
    end else if (lead_need != 2'd0 && !stop1) begin
      pending_lead_next   = in_byte;
      pending_needed_next = lead_need;
      pending_count_next  = 2'd0;
    end else begin
      pending_lead_next   = 8'd0;
      pending_needed_next = 2'd0;
      pending_count_next  = 2'd0;
    end
  end

  // Job record for the back part
  always_comb begin
    job.qn  = q_emit;
    job.tn  = trail_ok ? trail_len : 2'd0;
    job.t0  = trail0;
    job.t1  = trail1;
    job.eol = 1'b0;
    if (is_eol) begin
      job.tn  = 2'd1;
      job.t0  = udlf_pkg::CH_NUL;
      job.eol = 1'b1;
    end
    job_valid = accept && ((job.qn != 2'd0) || (job.tn != 2'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_lead   <= 8'd0;
      pending_needed <= 2'd0;
      pending_count  <= 2'd0;
      written_count  <= 8'd0;
      stopped        <= 1'b0;
    end else if (accept) begin
      pending_lead   <= pending_lead_next;
      pending_needed <= pending_needed_next;
      pending_count  <= pending_count_next;
      written_count  <= written_count_next;
      stopped        <= stopped_next;
    end
  end

  `UDLF_ASSERT_NOW(a_stop_no_pending, stopped, pending_needed == 2'd0, "pending sequence while truncated")
  `UDLF_ASSERT_NOW(a_count_below_need, pending_needed != 2'd0, pending_count < pending_needed, "continuation count overran lead")

endmodule
`default_nettype wire

### hw/rtl/udlf_queue.sv
`default_nettype none
`include "utf8_display_label_filter_macros.svh"
module udlf_queue #(
  parameter int DEPTH = udlf_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire udlf_pkg::job_t push_job,
  input  wire logic           pop,
  output udlf_pkg::job_t      head_job,
  output logic                head_valid,
  output logic                full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  udlf_pkg::job_t  slots [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;

  assign head_job   = slots[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CW'(DEPTH));

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

  `UDLF_ASSERT_NOW(a_no_overflow, push && !pop, !full, "request queue overflow")
  `UDLF_ASSERT_NOW(a_no_underflow, pop, head_valid, "pop from empty request queue")

endmodule
`default_nettype wire

### hw/rtl/udlf_back.sv
`default_nettype none
`include "utf8_display_label_filter_macros.svh"
module udlf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire udlf_pkg::job_t head_job,
  input  wire logic           head_valid,
  output logic                pop,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  output logic [7:0]          m_tdata,
  output logic                m_tuser,
  output logic                m_tlast
);

  logic [1:0] idx;
  logic [2:0] total;
  logic       load, is_last;
  logic [7:0] sel_byte;
  logic [1:0] rel;

  // Pick the result at the current index of the head request
  always_comb begin
    total   = {1'b0, head_job.qn} + {1'b0, head_job.tn};
    is_last = ({1'b0, idx} + 3'd1 == total);
    rel     = idx - head_job.qn;
    if (idx < head_job.qn)  sel_byte = udlf_pkg::CH_QMARK;
    else if (rel == 2'd0)   sel_byte = head_job.t0;
    else                    sel_byte = head_job.t1;
    load = head_valid && (!m_tvalid || m_tready);
    pop  = load && is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      idx      <= is_last ? 2'd0 : idx + 2'd1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= sel_byte;
      m_tlast <= is_last;
      m_tuser <= head_job.eol && is_last;
    end
  end

  `UDLF_ASSERT_NOW(a_eol_is_last, m_tvalid && m_tuser, m_tlast && m_tdata == udlf_pkg::CH_NUL, "terminator not last of run")

endmodule
`default_nettype wire

### hw/rtl/utf8_display_label_filter.sv
// An accepted byte's results pass the request queue register, then the output register.
// Throughput: one byte per cycle while each byte gives at most one result and m_tready
// is high; a byte with many results holds the serializer, the 4-entry queue absorbs it.
// Zero-result bytes are accepted every cycle the queue is not full, without touching it.
// Reset (rst, synchronous): clears label state, queue and output; capacity returns to 32.
`default_nettype none
module utf8_display_label_filter #(
  parameter int QUEUE_DEPTH = udlf_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [7:0] in_byte
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,    // [7:0] out_byte
  output logic             m_tuser,    // [0] end_of_label
  output logic             m_tlast,    // last_of_run
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]      label_capacity;
  logic            accept, push, pop, head_valid, full;
  udlf_pkg::job_t  job, head_job;

  assign pready   = 1'b1;
  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  // Only one register: every word address decodes to it
  assign prdata   = {24'd0, label_capacity};

  always_ff @(posedge clk) begin
    if (rst) begin
      label_capacity <= udlf_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && paddr == paddr) begin
      label_capacity <= pwdata[7:0];
    end
  end

  udlf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .capacity  (label_capacity),
    .job       (job),
    .job_valid (push)
  );

  udlf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (job),
    .pop        (pop),
    .head_job   (head_job),
    .head_valid (head_valid),
    .full       (full)
  );

  udlf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_job   (head_job),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire
